// ----- rtl/lth_pkg.sv -----
`default_nettype none

package lth_pkg;

  // Letters are coded a=0 .. z=25 in five bits.
  localparam int unsigned LETTER_BITS = 5;
  localparam int unsigned NUM_LETTERS = 26;

  // One bin per letter triple; the address is the three codes side by side.
  localparam int unsigned ADDR_BITS = 3 * LETTER_BITS;
  localparam int unsigned NUM_ENTRIES = 2 ** ADDR_BITS;

  // Default counter width and fixed output widths.
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned OUT_COUNT_BITS = 32;
  localparam int unsigned DISTINCT_BITS = 15;

  // Byte codes that the scanner looks at.
  localparam logic [7:0] LINE_FEED    = 8'h0a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

  // Request function codes.
  typedef enum logic {
    FUNC_SCAN = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

endpackage

`default_nettype wire

// ----- rtl/letter_trigram_histogram.sv -----
// Results: a request taken is registered into the second stage with its counter read, and its result,
// marked by done_o, is registered into the result registers, from where it is taken; the receiver cannot stall.
// Throughput: one request per cycle while busy is low, set by the single counter memory read at acceptance
// and written back in the next cycle, with the write forwarded to a read of the same bin.
// Reset: asynchronous, active low; afterwards busy stays high while a clearing pass writes zero
// to every memory entry, one per cycle.
`default_nettype none

module letter_trigram_histogram #(
  parameter int unsigned CountBits = lth_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 func_i,
  input  wire logic [7:0]                           text_byte_i,
  input  wire logic [lth_pkg::LETTER_BITS-1:0]      query_first_i,
  input  wire logic [lth_pkg::LETTER_BITS-1:0]      query_second_i,
  input  wire logic [lth_pkg::LETTER_BITS-1:0]      query_third_i,
  output logic                                      done_o,
  output logic [lth_pkg::OUT_COUNT_BITS-1:0]        bin_count_o,
  output logic                                      counted_o,
  output logic [lth_pkg::DISTINCT_BITS-1:0]         distinct_trigrams_o
);

  localparam int unsigned AddrBits = lth_pkg::ADDR_BITS;
  localparam int unsigned LetBits  = lth_pkg::LETTER_BITS;

  // Counter memory.
  logic [CountBits-1:0] mem_q [lth_pkg::NUM_ENTRIES];
  logic [CountBits-1:0] mem_rdata_q;
  logic [AddrBits-1:0]  rd_addr;
  logic                 mem_we;
  logic [AddrBits-1:0]  mem_waddr;
  logic [CountBits-1:0] mem_wdata;

  // Clearing pass after reset.
  logic                clr_active_q;
  logic [AddrBits-1:0] clr_addr_q;

  // Letter window.
  logic [LetBits-1:0] back_one_q, back_one_d;
  logic [LetBits-1:0] back_two_q, back_two_d;
  logic [1:0]         win_cnt_q, win_cnt_d;

  // Second stage: the request whose bin is being read.
  logic                s1_valid_q;
  logic                s1_scan_q;
  logic                s1_hit_q;
  logic [AddrBits-1:0] s1_addr_q;

  // Write of the previous cycle, kept for forwarding.
  logic                wr_valid_q;
  logic [AddrBits-1:0] wr_addr_q;
  logic [CountBits-1:0] wr_data_q;

  // Result registers.
  logic                               done_q;
  logic [lth_pkg::OUT_COUNT_BITS-1:0] bin_count_q;
  logic                               counted_q;
  logic [lth_pkg::DISTINCT_BITS-1:0]  distinct_q, distinct_d;

  logic                 accept;
  logic                 is_letter;
  logic [LetBits-1:0]   code;
  logic [7:0]           byte_off;
  logic                 query_ok;
  logic                 hit;
  logic [CountBits-1:0] old_count;
  logic [CountBits-1:0] new_count;
  logic                 s1_we;
  logic [lth_pkg::OUT_COUNT_BITS-1:0] bin_count_d;

  assign busy   = clr_active_q;
  assign accept = start && !busy;

  // Fold the byte to a letter code; anything outside A-Z and a-z is no letter.
  always_comb begin
    byte_off  = 8'd0;
    is_letter = 1'b0;
    if (text_byte_i >= lth_pkg::CHAR_LOWER_A && text_byte_i <= lth_pkg::CHAR_LOWER_Z) begin
      byte_off  = text_byte_i - lth_pkg::CHAR_LOWER_A;
      is_letter = 1'b1;
    end else if (text_byte_i >= lth_pkg::CHAR_UPPER_A &&
                 text_byte_i <= lth_pkg::CHAR_UPPER_Z) begin
      byte_off  = text_byte_i - lth_pkg::CHAR_UPPER_A;
      is_letter = 1'b1;
    end
    code = byte_off[LetBits-1:0];
  end

  // A query names a bin only if all three letters are in range.
  assign query_ok = (query_first_i < LetBits'(lth_pkg::NUM_LETTERS)) &&
                    (query_second_i < LetBits'(lth_pkg::NUM_LETTERS)) &&
                    (query_third_i < LetBits'(lth_pkg::NUM_LETTERS));

  // Window update and bin selection for the request being taken.
  always_comb begin
    back_one_d = back_one_q;
    back_two_d = back_two_q;
    win_cnt_d  = win_cnt_q;
    hit        = 1'b0;
    rd_addr    = {back_two_q, back_one_q, code};
    if (func_i == lth_pkg::FUNC_READ) begin
      rd_addr = {query_first_i, query_second_i, query_third_i};
      hit     = query_ok;
    end else if (text_byte_i != lth_pkg::LINE_FEED) begin
      if (!is_letter) begin
        win_cnt_d = 2'd0;
      end else begin
        hit        = (win_cnt_q == 2'd2);
        back_two_d = back_one_q;
        back_one_d = code;
        if (win_cnt_q != 2'd2) begin
          win_cnt_d = win_cnt_q + 2'd1;
        end
      end
    end
  end

  // Window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_one_q <= '0;
      back_two_q <= '0;
      win_cnt_q  <= '0;
    end else if (accept) begin
      back_one_q <= back_one_d;
      back_two_q <= back_two_d;
      win_cnt_q  <= win_cnt_d;
    end
  end

  // Stage register for the request whose counter is read this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_scan_q  <= 1'b0;
      s1_hit_q   <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_scan_q  <= (func_i == lth_pkg::FUNC_SCAN);
      s1_hit_q   <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= rd_addr;
  end

  // Take the last write when it went to the bin just read, then count with saturation.
  always_comb begin
    old_count = mem_rdata_q;
    if (wr_valid_q && wr_addr_q == s1_addr_q) begin
      old_count = wr_data_q;
    end
    new_count = old_count;
    if (old_count != '1) begin
      new_count = old_count + CountBits'(1);
    end
    s1_we       = s1_valid_q && s1_scan_q && s1_hit_q;
    distinct_d  = distinct_q;
    bin_count_d = '0;
    if (s1_valid_q && s1_hit_q) begin
      if (s1_scan_q) begin
        bin_count_d = lth_pkg::OUT_COUNT_BITS'(new_count);
        if (old_count == '0) begin
          distinct_d = distinct_q + lth_pkg::DISTINCT_BITS'(1);
        end
      end else begin
        bin_count_d = lth_pkg::OUT_COUNT_BITS'(old_count);
      end
    end
  end

  // Memory write port: the clearing pass owns it until it is done.
  always_comb begin
    mem_we    = s1_we;
    mem_waddr = s1_addr_q;
    mem_wdata = new_count;
    if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[rd_addr];
  end

  // Clearing pass sweeps every entry once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + AddrBits'(1);
      if (clr_addr_q == '1) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // Forwarding record of the counter write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= s1_we;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= s1_addr_q;
    wr_data_q <= new_count;
  end

  // Result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      distinct_q <= '0;
    end else begin
      done_q     <= s1_valid_q;
      distinct_q <= distinct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      bin_count_q <= bin_count_d;
      counted_q   <= s1_we;
    end
  end

  assign done_o              = done_q;
  assign bin_count_o         = bin_count_q;
  assign counted_o           = counted_q;
  assign distinct_trigrams_o = distinct_q;

endmodule

`default_nettype wire

// ----- rtl/lth_checker.sv -----
`default_nettype none

module lth_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic                                 func_i,
  input wire logic                                 done_o,
  input wire logic                                 counted_o,
  input wire logic [lth_pkg::DISTINCT_BITS-1:0]    distinct_trigrams_o
);

  // Every request taken gives its result, through the second stage and the result registers.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("request taken without a result two cycles later");

  // No result without a matching request taken earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result strobe without a matching request");

  // Only a scan request can count a trigram.
  a_counted_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && counted_o) |-> $past(func_i == lth_pkg::FUNC_SCAN, 2))
    else $error("read request reported a counted trigram");

  // The distinct total moves only with a result, and by at most one.
  a_distinct_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(distinct_trigrams_o) |->
      (done_o && distinct_trigrams_o ==
        lth_pkg::DISTINCT_BITS'($past(distinct_trigrams_o) + 1)))
    else $error("distinct trigram total changed unexpectedly");

endmodule

bind letter_trigram_histogram lth_checker u_lth_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .start               (start),
  .busy                (busy),
  .func_i              (func_i),
  .done_o              (done_o),
  .counted_o           (counted_o),
  .distinct_trigrams_o (distinct_trigrams_o)
);

`default_nettype wire
